>>> design/ccp_pkg.sv
// Shared types, codes and decode helpers for the constant pool parser.
package ccp_pkg;

  // Constant pool tag codes.
  localparam logic [7:0] TAG_UTF8      = 8'd1;
  localparam logic [7:0] TAG_INTEGER   = 8'd3;
  localparam logic [7:0] TAG_FLOAT     = 8'd4;
  localparam logic [7:0] TAG_LONG      = 8'd5;
  localparam logic [7:0] TAG_DOUBLE    = 8'd6;
  localparam logic [7:0] TAG_CLASS     = 8'd7;
  localparam logic [7:0] TAG_STRING    = 8'd8;
  localparam logic [7:0] TAG_FIELDREF  = 8'd9;
  localparam logic [7:0] TAG_METHODREF = 8'd10;
  localparam logic [7:0] TAG_IFMETHREF = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE  = 8'd12;

  // Register indexes on the configuration port (word address).
  localparam logic REG_POOL_COUNT = 1'b0;

  localparam int unsigned PADDR_W = 3;
  localparam logic [15:0] POOL_COUNT_RST = 16'd1;

  // Kind of a result beat.
  typedef enum logic [1:0] {
    KIND_FIXED    = 2'd0,
    KIND_STR_BYTE = 2'd1,
    KIND_STR_HDR  = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_e;

  // Parser phase, one-hot.
  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_TAG    = 7'b0000010,
    PH_OPER   = 7'b0000100,
    PH_ULEN   = 7'b0001000,
    PH_UBYTES = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_HALT   = 7'b1000000
  } phase_e;

  // One accepted input beat.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_of_pool;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [15:0] entry_slot;
    logic [7:0]  entry_tag;
    kind_e       result_kind;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [7:0]  string_byte;
    logic        string_last;
    logic        pool_done;
  } result_t;

  // Number of fixed operand bytes of a tag; zero for Utf8 and unknown tags.
  function automatic logic [3:0] fixed_len(input logic [7:0] tag);
    logic [3:0] len;
    case (tag)
      TAG_CLASS, TAG_STRING: len = 4'd2;
      TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
      TAG_IFMETHREF, TAG_NAMETYPE: len = 4'd4;
      TAG_LONG, TAG_DOUBLE: len = 4'd8;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // Tags whose operands split into a first and a second word.
  function automatic logic two_operands(input logic [7:0] tag);
    return (tag == TAG_LONG) || (tag == TAG_DOUBLE) || (tag == TAG_FIELDREF) ||
           (tag == TAG_METHODREF) || (tag == TAG_IFMETHREF) || (tag == TAG_NAMETYPE);
  endfunction

  // Tags that occupy two pool slots.
  function automatic logic wide_entry(input logic [7:0] tag);
    return (tag == TAG_LONG) || (tag == TAG_DOUBLE);
  endfunction

endpackage

>>> design/class_constant_pool_parser_top.sv
// Top level of the class file constant pool parser.
// The block parses the constant pool area of a class file at one byte per clock cycle:
// each byte is taken into an input register and decoded combinationally against the
// parser state once the output register has room, and any result is loaded into the
// output register, where the result beat is held until the sink takes it. The parser
// state updates once per consumed byte, which sets the rate of one byte per cycle;
// stalls on the result side hold the input side only while a result is waiting. A beat
// with tuser set restarts parsing at slot 1 with that byte as tag (for a pool count
// above one). Each fixed entry gives one result on its last operand byte, a Utf8 entry
// gives a header result and then one result per content byte (tlast on the last one),
// and pool_done marks the final result of the pool. An unknown tag gives an error result
// and all bytes are dropped until the next restart. The pool count register sits at
// address 0 and may only be written while the block is idle.
module class_constant_pool_parser_top
  import ccp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Byte stream in.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] byte_value
  input  logic               s_axis_tuser,   // [0] first_of_pool
  // Result stream out.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [15:0] entry_slot, [23:16] entry_tag, [55:24] first_word,
  // [87:56] second_word, [95:88] string_byte
  output logic [95:0]        m_axis_tdata,
  output logic [2:0]         m_axis_tuser,   // [1:0] result_kind, [2] pool_done
  output logic               m_axis_tlast,   // string_last
  // Configuration.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] pool_count;
  in_beat_t    s_beat, in_beat;
  logic        in_valid, fire, out_free, res_valid;
  result_t     res, out_res;

  ccp_apb_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pool_count_o(pool_count)
  );

  assign s_beat.byte_value    = s_axis_tdata;
  assign s_beat.first_of_pool = s_axis_tuser;

  ccp_in_reg u_in (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .s_beat_i (s_beat),
    .consume_i(fire),
    .valid_o  (in_valid),
    .beat_o   (in_beat)
  );

  // A held byte is decoded once the result register has room.
  assign fire = in_valid && out_free;

  ccp_parser u_parser (
    .clk_i, .rst_ni,
    .fire_i      (fire),
    .beat_i      (in_beat),
    .pool_count_i(pool_count),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ccp_out_reg u_out (
    .clk_i, .rst_ni,
    .load_i   (fire && res_valid),
    .res_i    (res),
    .free_o   (out_free),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .res_o    (out_res)
  );

  // Pack the result beat.
  assign m_axis_tdata = {out_res.string_byte, out_res.second_word, out_res.first_word,
                         out_res.entry_tag, out_res.entry_slot};
  assign m_axis_tuser = {out_res.pool_done, out_res.result_kind};
  assign m_axis_tlast = out_res.string_last;

endmodule

>>> design/ccp_apb_regs.sv
// APB configuration register holding the constant pool count.
module ccp_apb_regs
  import ccp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [15:0]        pool_count_o
);

  logic [15:0] pool_count_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Register write on the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_count_q <= POOL_COUNT_RST;
    end else if (wr_en && (paddr[PADDR_W-1] == REG_POOL_COUNT)) begin
      pool_count_q <= pwdata[15:0];
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_POOL_COUNT) begin
      prdata = {16'd0, pool_count_q};
    end
  end

  assign pool_count_o = pool_count_q;

endmodule

>>> design/ccp_in_reg.sv
// Input register that holds one byte beat until the parser consumes it.
module ccp_in_reg
  import ccp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  in_beat_t s_beat_i,
  input  logic     consume_i,
  output logic     valid_o,
  output in_beat_t beat_o
);

  logic     valid_q;
  in_beat_t beat_q;

  // Room whenever the slot is empty or its beat leaves this cycle.
  assign s_ready_o = !valid_q || consume_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      beat_q <= s_beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

>>> design/ccp_parser.sv
// Parser state and the combinational decode of one constant pool byte.
module ccp_parser
  import ccp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  in_beat_t    beat_i,
  input  logic [15:0] pool_count_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  phase_e      phase_q, phase_d, phase_eff;
  logic [7:0]  tag_q, tag_d;
  logic [15:0] slot_q, slot_d, slot_eff;
  logic [15:0] rem_q, rem_d, rem_n;
  logic [31:0] opa_q, opa_d, opa_n;
  logic [31:0] opb_q, opb_d, opb_n;
  logic [7:0]  b;
  logic [3:0]  flen_new, flen_cur, oper_idx;
  logic [16:0] next_slot;
  logic        fin_done;
  logic        restart, empty_pool;

  assign b          = beat_i.byte_value;
  assign restart    = beat_i.first_of_pool;
  assign empty_pool = (pool_count_i <= 16'd1);
  assign flen_new   = fixed_len(b);
  assign flen_cur   = fixed_len(tag_q);
  assign oper_idx   = flen_cur - rem_q[3:0];

  // Slot that follows the current entry, and whether the pool ends there.
  assign next_slot = {1'b0, slot_eff} + (wide_entry(tag_q) ? 17'd2 : 17'd1);
  assign fin_done  = (next_slot >= {1'b0, pool_count_i});

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_d  = phase_q;
    tag_d    = tag_q;
    slot_d   = slot_q;
    rem_d    = rem_q;
    opa_d    = opa_q;
    opb_d    = opb_q;
    opa_n    = opa_q;
    opb_n    = opb_q;
    rem_n    = rem_q;
    res_valid_o = 1'b0;
    res_o.entry_slot  = slot_q;
    res_o.entry_tag   = tag_q;
    res_o.result_kind = KIND_FIXED;
    res_o.first_word  = '0;
    res_o.second_word = '0;
    res_o.string_byte = '0;
    res_o.string_last = 1'b0;
    res_o.pool_done   = 1'b0;

    phase_eff = phase_q;
    slot_eff  = slot_q;
    if (restart) begin
      slot_eff = 16'd1;
      slot_d   = 16'd1;
      rem_d    = '0;
      phase_eff = empty_pool ? PH_DONE : PH_TAG;
      phase_d   = phase_eff;
    end
    res_o.entry_slot = slot_eff;

    case (phase_eff)
      PH_TAG: begin
        tag_d = b;
        opa_d = '0;
        opb_d = '0;
        res_o.entry_tag = b;
        if (b == TAG_UTF8) begin
          phase_d = PH_ULEN;
          rem_d   = 16'd2;
        end else if (flen_new == 4'd0) begin
          // Unknown tag: report and stop until the next restart.
          phase_d = PH_HALT;
          res_valid_o       = 1'b1;
          res_o.result_kind = KIND_ERROR;
          res_o.pool_done   = 1'b1;
        end else begin
          phase_d = PH_OPER;
          rem_d   = {12'd0, flen_new};
        end
      end

      PH_OPER: begin
        // For split tags, bytes of the second half go into the second word.
        if (two_operands(tag_q) && (oper_idx >= (flen_cur >> 1))) begin
          opb_n = {opb_q[23:0], b};
        end else begin
          opa_n = {opa_q[23:0], b};
        end
        opa_d = opa_n;
        opb_d = opb_n;
        rem_n = rem_q - 16'd1;
        rem_d = rem_n;
        if (rem_n == '0) begin
          phase_d = fin_done ? PH_DONE : PH_TAG;
          slot_d  = next_slot[15:0];
          res_valid_o       = 1'b1;
          res_o.result_kind = KIND_FIXED;
          res_o.first_word  = opa_n;
          res_o.second_word = opb_n;
          res_o.pool_done   = fin_done;
        end
      end

      PH_ULEN: begin
        opa_n = {16'd0, opa_q[7:0], b};
        opa_d = opa_n;
        rem_n = (rem_q != '0) ? rem_q - 16'd1 : '0;
        rem_d = rem_n;
        if (rem_n == '0) begin
          res_valid_o       = 1'b1;
          res_o.result_kind = KIND_STR_HDR;
          if (opa_n == '0) begin
            // Empty string: the header closes the entry.
            phase_d = fin_done ? PH_DONE : PH_TAG;
            slot_d  = next_slot[15:0];
            res_o.pool_done = fin_done;
          end else begin
            phase_d = PH_UBYTES;
            rem_d   = opa_n[15:0];
            res_o.first_word = opa_n;
          end
        end
      end

      PH_UBYTES: begin
        rem_n = (rem_q != '0) ? rem_q - 16'd1 : '0;
        rem_d = rem_n;
        res_valid_o       = 1'b1;
        res_o.result_kind = KIND_STR_BYTE;
        res_o.first_word  = opa_q;
        res_o.string_byte = b;
        if (rem_n == '0) begin
          phase_d = fin_done ? PH_DONE : PH_TAG;
          slot_d  = next_slot[15:0];
          res_o.string_last = 1'b1;
          res_o.pool_done   = fin_done;
        end
      end

      default: begin
      end
    endcase
  end

  // State registers advance once per consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tag_q   <= '0;
      slot_q  <= '0;
      rem_q   <= '0;
      opa_q   <= '0;
      opb_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      slot_q  <= slot_d;
      rem_q   <= rem_d;
      opa_q   <= opa_d;
      opb_q   <= opb_d;
    end
  end

endmodule

>>> design/ccp_out_reg.sv
// Result register that holds one result beat until the sink takes it.
module ccp_out_reg
  import ccp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  // The register can take a new beat when empty or being drained.
  assign free_o = !valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule

>>> design/ccp_checker.sv
// Port-level checks for the constant pool parser, bound to the top level.
module ccp_checker
  import ccp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [95:0]        m_axis_tdata,
  input logic [2:0]         m_axis_tuser,
  input logic               m_axis_tlast,
  input logic               pready
);

  // The last-byte mark only appears on string byte beats.
  a_last_is_str: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1:0] == KIND_STR_BYTE)
    else $error("tlast on a beat that is not a string byte");

  // An error beat always ends the pool.
  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == KIND_ERROR |-> m_axis_tuser[2])
    else $error("error beat without pool_done");

  // A string byte that is not the last one never ends the pool.
  a_mid_str: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == KIND_STR_BYTE && !m_axis_tlast
    |-> !m_axis_tuser[2])
    else $error("pool_done inside a string");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // The configuration port never inserts wait states.
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind class_constant_pool_parser_top ccp_checker u_ccp_checker (.*);

>>> verif/class_constant_pool_parser_checker.sv
// Result checker for the constant pool parser: predicts each result beat and compares it.
module class_constant_pool_parser_checker
  import ccp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] byte_value
  input  logic               s_axis_tuser,   // [0] first_of_pool
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [15:0] entry_slot, [23:16] entry_tag, [55:24] first_word,
  // [87:56] second_word, [95:88] string_byte
  input  logic [95:0]        m_axis_tdata,
  input  logic [2:0]         m_axis_tuser,   // [1:0] result_kind, [2] pool_done
  input  logic               m_axis_tlast,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the parser state and its register.
  logic [15:0] pool_count;
  phase_e      phase;
  logic [7:0]  cur_tag;
  logic [15:0] slot_no;
  logic [15:0] bytes_left;
  logic [31:0] word_a;
  logic [31:0] word_b;

  result_t expected_entries[$];
  int      failures;

  // Operand byte count of a fixed-size tag; zero for Utf8 and unknown tags.
  function automatic logic [3:0] operand_bytes(input logic [7:0] tag);
    case (tag)
      TAG_CLASS, TAG_STRING: return 4'd2;
      TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
      TAG_IFMETHREF, TAG_NAMETYPE: return 4'd4;
      TAG_LONG, TAG_DOUBLE: return 4'd8;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic split_operands(input logic [7:0] tag);
    return (tag == TAG_LONG) || (tag == TAG_DOUBLE) ||
           ((tag >= TAG_FIELDREF) && (tag <= TAG_NAMETYPE));
  endfunction

  // Advances past the finished entry and tells whether the pool ends with it.
  function automatic logic close_entry();
    logic [16:0] nxt;
    logic        ends;
    nxt  = {1'b0, slot_no} + (((cur_tag == TAG_LONG) || (cur_tag == TAG_DOUBLE)) ? 17'd2 : 17'd1);
    ends = (nxt >= {1'b0, pool_count});
    phase   = ends ? PH_DONE : PH_TAG;
    slot_no = nxt[15:0];
    return ends;
  endfunction

  task automatic post_entry(input logic [15:0] slot, input kind_e kind, input logic [31:0] a,
                            input logic [31:0] b, input logic [7:0] sb, input logic last,
                            input logic done);
    result_t r;
    r.entry_slot  = slot;
    r.entry_tag   = cur_tag;
    r.result_kind = kind;
    r.first_word  = a;
    r.second_word = b;
    r.string_byte = sb;
    r.string_last = last;
    r.pool_done   = done;
    expected_entries.push_back(r);
  endtask

  // Runs one accepted byte through the shadow parser.
  task automatic parse_byte(input logic [7:0] b, input logic restart);
    logic [3:0]  nbytes;
    logic [15:0] slot;
    logic        ends;
    if (restart) begin
      slot_no    = 16'd1;
      bytes_left = '0;
      if (pool_count <= 16'd1) begin
        phase = PH_DONE;
        return;
      end
      phase = PH_TAG;
    end
    case (phase)
      PH_TAG: begin
        cur_tag = b;
        word_a  = '0;
        word_b  = '0;
        if (b == TAG_UTF8) begin
          phase      = PH_ULEN;
          bytes_left = 16'd2;
        end else if (operand_bytes(b) == 4'd0) begin
          phase = PH_HALT;
          post_entry(slot_no, KIND_ERROR, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          phase      = PH_OPER;
          bytes_left = {12'd0, operand_bytes(b)};
        end
      end
      PH_OPER: begin
        nbytes = operand_bytes(cur_tag);
        if ((bytes_left == '0) || (bytes_left > {12'd0, nbytes})) begin
          bytes_left = {12'd0, nbytes};
        end
        // The second half of a split operand field fills the second word.
        if (split_operands(cur_tag) && ((int'(nbytes) - int'(bytes_left)) >= int'(nbytes) / 2)) begin
          word_b = {word_b[23:0], b};
        end else begin
          word_a = {word_a[23:0], b};
        end
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == '0) begin
          slot = slot_no;
          ends = close_entry();
          post_entry(slot, KIND_FIXED, word_a, word_b, '0, 1'b0, ends);
        end
      end
      PH_ULEN: begin
        word_a = {16'd0, word_a[7:0], b};
        if (bytes_left != '0) begin
          bytes_left = bytes_left - 16'd1;
        end
        if (bytes_left == '0) begin
          slot = slot_no;
          if (word_a == '0) begin
            ends = close_entry();
            post_entry(slot, KIND_STR_HDR, '0, '0, '0, 1'b0, ends);
          end else begin
            phase      = PH_UBYTES;
            bytes_left = word_a[15:0];
            post_entry(slot, KIND_STR_HDR, word_a, '0, '0, 1'b0, 1'b0);
          end
        end
      end
      PH_UBYTES: begin
        if (bytes_left != '0) begin
          bytes_left = bytes_left - 16'd1;
        end
        slot = slot_no;
        if (bytes_left == '0) begin
          ends = close_entry();
          post_entry(slot, KIND_STR_BYTE, word_a, '0, b, 1'b1, ends);
        end else begin
          post_entry(slot, KIND_STR_BYTE, word_a, '0, b, 1'b0, 1'b0);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Outputs are compared before the same edge's input beat is predicted, so a
  // result can never be matched against the byte that is accepted with it.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      pool_count = POOL_COUNT_RST;
      phase      = PH_IDLE;
      cur_tag    = '0;
      slot_no    = '0;
      bytes_left = '0;
      word_a     = '0;
      word_b     = '0;
      expected_entries.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_entries.size() == 0) begin
          failures++;
          $display("%0t: unexpected result beat, expected none, got tdata %h tuser %h tlast %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          want = expected_entries.pop_front();
          check_field("entry_slot", want.entry_slot, m_axis_tdata[15:0]);
          check_field("entry_tag", want.entry_tag, m_axis_tdata[23:16]);
          check_field("result_kind", want.result_kind, m_axis_tuser[1:0]);
          check_field("first_word", want.first_word, m_axis_tdata[55:24]);
          check_field("second_word", want.second_word, m_axis_tdata[87:56]);
          check_field("string_byte", want.string_byte, m_axis_tdata[95:88]);
          check_field("string_last", want.string_last, m_axis_tlast);
          check_field("pool_done", want.pool_done, m_axis_tuser[2]);
        end
      end
      // Register writes and read-back.
      if (psel && penable && pready && (paddr[PADDR_W-1:2] == REG_POOL_COUNT)) begin
        if (pwrite) begin
          pool_count = pwdata[15:0];
        end else begin
          check_field("pool_count read", {16'd0, pool_count}, prdata);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tuser);
      end
    end
    fail_count_o <= failures;
    pending_o    <= expected_entries.size();
  end

endmodule

>>> verif/tb_class_constant_pool_parser_top.sv
// Testbench top for the constant pool parser: clock, reset, byte stimulus and the verdict.
module tb_class_constant_pool_parser_top;
  import ccp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [PADDR_W-1:0] POOL_COUNT_ADDR = {REG_POOL_COUNT, 2'b00};
  localparam int BEATS_PER_PHASE = 260;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;    // [7:0] byte_value
  logic               s_axis_tuser = 1'b0;  // [0] first_of_pool
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // [15:0] entry_slot, [23:16] entry_tag, [55:24] first_word,
  // [87:56] second_word, [95:88] string_byte
  logic [95:0]        m_axis_tdata;
  logic [2:0]         m_axis_tuser;         // [1:0] result_kind, [2] pool_done
  logic               m_axis_tlast;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int          fail_count;
  int          pending;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          beats_sent = 0;
  logic [15:0] pool_count_now = POOL_COUNT_RST;

  class_constant_pool_parser_top uut (.*);

  class_constant_pool_parser_checker checker_i (
    .*,
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 100 MHz clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Result side back-pressure.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("class_constant_pool_parser_top verification failed");
    $finish;
  end

  // Offers one byte, with random idle cycles ahead of it, and waits for the beat.
  task automatic send_beat(input logic [7:0] b, input logic first);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  // Holds the byte stream until every expected result is out, then lets the pipeline settle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the pool count while the parser is quiet, then reads it back.
  task automatic set_pool_count(input logic [15:0] count);
    drain();
    apb_access(1'b1, POOL_COUNT_ADDR, {16'd0, count});
    apb_access(1'b0, POOL_COUNT_ADDR, '0);
    pool_count_now = count;
  endtask

  function automatic logic [7:0] pick_tag();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) begin
      // Values that no constant pool entry uses.
      case ($urandom_range(2))
        0: return 8'h00;
        1: return 8'h02;
        default: return 8'($urandom_range(13, 255));
      endcase
    end
    if (r < 30) return TAG_UTF8;
    case ($urandom_range(9))
      0: return TAG_INTEGER;
      1: return TAG_FLOAT;
      2: return TAG_LONG;
      3: return TAG_DOUBLE;
      4: return TAG_CLASS;
      5: return TAG_STRING;
      6: return TAG_FIELDREF;
      7: return TAG_METHODREF;
      8: return TAG_IFMETHREF;
      default: return TAG_NAMETYPE;
    endcase
  endfunction

  // Operand bytes lean toward the all-zero and all-one extremes now and then.
  function automatic logic [7:0] operand_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Sends one complete entry: tag, then its operands or its length and text.
  task automatic send_entry(input logic [7:0] tag, input logic first);
    logic [15:0] len;
    int unsigned r;
    send_beat(tag, first);
    if (tag == TAG_UTF8) begin
      r   = $urandom_range(99);
      len = (r < 10) ? 16'd0 : (r < 85) ? 16'($urandom_range(1, 8)) : 16'($urandom_range(9, 40));
      send_beat(len[15:8], 1'b0);
      send_beat(len[7:0], 1'b0);
      repeat (len) send_beat(8'($urandom_range(255)), 1'b0);
    end else begin
      repeat (fixed_len(tag)) send_beat(operand_byte(), 1'b0);
    end
  endtask

  // One pool: mostly well-formed entries, with occasional broken or paused sequences.
  task automatic run_pool();
    int unsigned r;
    int unsigned slot;
    int unsigned budget;
    logic [15:0] count;
    logic [7:0]  tag;
    logic        first;
    r = $urandom_range(99);
    if (r < 8) count = 16'($urandom_range(1, 2));
    else if (r < 75) count = 16'($urandom_range(3, 10));
    else if (r < 92) count = 16'($urandom_range(11, 40));
    else count = 16'hFFFF;
    if (count != pool_count_now) set_pool_count(count);
    budget = (count == 16'hFFFF) ? $urandom_range(5, 30) : 64;
    slot   = 1;
    first  = 1'b1;
    if (count <= 16'd1) begin
      send_entry(pick_tag(), 1'b1);
    end
    while ((slot < pool_count_now) && (budget > 0)) begin
      r = $urandom_range(199);
      if (r < 4) begin
        drain();
      end else if (r < 7 && !first) begin
        // New count while the pool is in progress; it takes effect at the next entry end.
        set_pool_count(16'($urandom_range(1, slot + 2)));
      end else if (r < 13) begin
        // Entry cut short by a restart.
        send_beat(TAG_INTEGER, first);
        repeat ($urandom_range(0, 3)) send_beat(operand_byte(), 1'b0);
        first = 1'b1;
        slot  = 1;
      end else if (r < 17) begin
        send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      tag = pick_tag();
      send_entry(tag, first);
      first = 1'b0;
      budget--;
      if (fixed_len(tag) == 4'd0 && tag != TAG_UTF8) break;
      slot += ((tag == TAG_LONG) || (tag == TAG_DOUBLE)) ? 2 : 1;
    end
    // Trailing bytes after the last entry; the block drops them once the pool has ended or halted.
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(255)), 1'b0);
    end
  endtask

  initial begin
    wait (rst_ni === 1'b1);

    // Directed part: bytes before any restart are dropped.
    send_beat(8'hA5, 1'b0);
    // A pool count of one parses nothing.
    send_beat(TAG_CLASS, 1'b1);

    // Class with maximal index, a pause mid-pool, then a Long in the last slot.
    set_pool_count(16'd3);
    send_beat(TAG_CLASS, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    drain();
    send_beat(TAG_LONG, 1'b0);
    send_beat(8'h80, 1'b0);
    repeat (6) send_beat(8'h00, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h5A, 1'b0);

    // Largest pool: empty string, unknown tag, a byte while halted.
    set_pool_count(16'hFFFF);
    send_beat(TAG_UTF8, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(TAG_CLASS, 1'b0);
    // Restart in the middle of an Integer.
    send_beat(TAG_INTEGER, 1'b1);
    send_beat(8'h12, 1'b0);
    send_beat(TAG_STRING, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'h07, 1'b0);
    // Count lowered mid-pool: the next entry ends the pool.
    set_pool_count(16'd2);
    send_beat(TAG_FLOAT, 1'b0);
    repeat (4) send_beat(8'hC3, 1'b0);

    // Random part, one idling pattern per phase.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin src_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      while (beats_sent < 25 + (ph + 1) * BEATS_PER_PHASE) run_pool();
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (pending != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("class_constant_pool_parser_top verification clean");
    end else begin
      $display("class_constant_pool_parser_top verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/ccp_pkg.sv
design/ccp_apb_regs.sv
design/ccp_in_reg.sv
design/ccp_parser.sv
design/ccp_out_reg.sv
design/class_constant_pool_parser_top.sv
design/ccp_checker.sv
verif/class_constant_pool_parser_checker.sv
verif/tb_class_constant_pool_parser_top.sv
